@@ src/deq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the double-ended queue core.
package deq_pkg;

  localparam int unsigned DataW = 32;

  typedef logic signed [DataW-1:0] data_t;

  // Operation codes carried on func_i.
  typedef enum logic [2:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_CLEAR      = 3'd4
  } func_e;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_RESULT
  } state_e;

  // Which cached end is refreshed from the store read.
  typedef enum logic [1:0] {
    RD_NONE,
    RD_FRONT,
    RD_BACK
  } rd_sel_e;

endpackage

@@ src/double_ended_queue_core.sv @@
`timescale 1ns / 1ps
// Top level of the double-ended queue core: sequencer, pointers and result register.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------------
//  in      | sink      | in_valid_i / in_stall_o | func_i, value_i
//  out     | source    | out_valid_o/out_stall_i | ok_o, popped_value_o, front_value_o,
//          |           |                         | back_value_o, count_o, is_empty_o,
//          |           |                         | is_full_o
//
// Each beat is accepted in ST_IDLE, which updates head and count, writes the
// store on a push, or issues a read on a pop; ST_RESULT then takes the read data of
// the single store port and loads the result register once that register is free.
// Front and back elements are cached in registers, so each operation needs at most
// one store access; a pop refetches only the end it removed.
// Reset clears the sequencer, head, count and the result valid; the store is never
// read before written, so it needs no clearing.
// A stalled result holds in the output register; the next beat is still accepted, and
// its own result waits in the sequencer (store read data holds) until the register frees.
module double_ended_queue_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input beats
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   func_i,
  input  logic signed [31:0]           value_i,
  // result beats
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         ok_o,
  output logic signed [31:0]           popped_value_o,
  output logic signed [31:0]           front_value_o,
  output logic signed [31:0]           back_value_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o,
  output logic                         is_empty_o,
  output logic                         is_full_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  // (head + n - 1) mod DEPTH, n >= 1
  function automatic logic [IdxW-1:0] back_idx(input logic [IdxW-1:0] head,
                                               input logic [CntW-1:0] n);
    logic [SumW-1:0] s;
    s = SumW'(head) + SumW'(n) - SumW'(1);
    if (s >= SumW'(DEPTH)) begin
      s = s - SumW'(DEPTH);
    end
    return s[IdxW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  deq_pkg::state_e  state_q, state_d;
  logic [IdxW-1:0]  head_q, head_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  deq_pkg::data_t   front_q, front_d;   // cached front element
  deq_pkg::data_t   back_q, back_d;     // cached back element
  logic             ok_q, ok_d;
  deq_pkg::data_t   popped_q, popped_d;
  deq_pkg::rd_sel_e rd_sel_q, rd_sel_d;

  logic             out_valid_q, out_valid_d;
  logic             out_ok_q;
  deq_pkg::data_t   out_popped_q, out_front_q, out_back_q;
  logic [CntW-1:0]  out_cnt_q;

  logic             accept;
  logic             load;
  logic             empty, full;

  // store port
  logic             ram_we, ram_re;
  logic [IdxW-1:0]  ram_addr;
  deq_pkg::data_t   ram_wdata, ram_rdata;

  deq_pkg::func_e   func;
  deq_pkg::data_t   res_front, res_back;
  logic [CntW-1:0]  cnt_dec;

  assign func    = deq_pkg::func_e'(func_i);
  assign empty   = (cnt_q == '0);
  assign full    = (cnt_q == FullCnt);
  assign cnt_dec = cnt_q - CntW'(1);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      deq_pkg::ST_IDLE:   if (in_valid_i) state_d = deq_pkg::ST_RESULT;
      deq_pkg::ST_RESULT: if (load) state_d = deq_pkg::ST_IDLE;
      default:            state_d = deq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != deq_pkg::ST_IDLE);
    accept     = (state_q == deq_pkg::ST_IDLE) && in_valid_i;
    load       = (state_q == deq_pkg::ST_RESULT) && (!out_valid_q || !out_stall_i);
  end

  // ---------------------------------------------------------------------------
  // Operation decode at accept: pointers, store access, cached ends
  // ---------------------------------------------------------------------------
  always_comb begin
    head_d    = head_q;
    cnt_d     = cnt_q;
    front_d   = front_q;
    back_d    = back_q;
    ok_d      = ok_q;
    popped_d  = popped_q;
    rd_sel_d  = rd_sel_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = head_q;
    ram_wdata = value_i;

    if (accept) begin
      ok_d     = 1'b0;
      popped_d = '0;
      rd_sel_d = deq_pkg::RD_NONE;
      unique case (func)
        deq_pkg::FUNC_PUSH_FRONT: begin
          if (!full) begin
            head_d   = (head_q == '0) ? LastIdx : head_q - IdxW'(1);
            ram_we   = 1'b1;
            ram_addr = head_d;
            cnt_d    = cnt_q + CntW'(1);
            front_d  = value_i;
            if (empty) back_d = value_i;
            ok_d     = 1'b1;
          end
        end
        deq_pkg::FUNC_PUSH_BACK: begin
          if (!full) begin
            cnt_d    = cnt_q + CntW'(1);
            ram_we   = 1'b1;
            ram_addr = back_idx(head_q, cnt_d);
            back_d   = value_i;
            if (empty) front_d = value_i;
            ok_d     = 1'b1;
          end
        end
        deq_pkg::FUNC_POP_FRONT: begin
          if (!empty) begin
            popped_d = front_q;
            head_d   = (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
            cnt_d    = cnt_dec;
            ok_d     = 1'b1;
            if (cnt_dec != '0) begin
              ram_re   = 1'b1;
              ram_addr = head_d;
              rd_sel_d = deq_pkg::RD_FRONT;
            end
          end
        end
        deq_pkg::FUNC_POP_BACK: begin
          if (!empty) begin
            popped_d = back_q;
            cnt_d    = cnt_dec;
            ok_d     = 1'b1;
            if (cnt_dec != '0) begin
              ram_re   = 1'b1;
              ram_addr = back_idx(head_q, cnt_dec);
              rd_sel_d = deq_pkg::RD_BACK;
            end
          end
        end
        deq_pkg::FUNC_CLEAR: begin
          cnt_d  = '0;
          head_d = '0;
          ok_d   = 1'b1;
        end
        default: ;  // undefined code: no change, refused
      endcase
    end else if (load) begin
      // fold the refetched end into the cache
      front_d = res_front;
      back_d  = res_back;
    end
  end

  // Result view: the end just refetched comes straight from the store.
  always_comb begin
    res_front = (rd_sel_q == deq_pkg::RD_FRONT) ? ram_rdata : front_q;
    res_back  = (rd_sel_q == deq_pkg::RD_BACK)  ? ram_rdata : back_q;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= deq_pkg::ST_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      rd_sel_q    <= deq_pkg::RD_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      rd_sel_q    <= rd_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q  <= front_d;
    back_q   <= back_d;
    ok_q     <= ok_d;
    popped_q <= popped_d;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_ok_q     <= ok_q;
      out_popped_q <= popped_q;
      out_front_q  <= empty ? '0 : res_front;
      out_back_q   <= empty ? '0 : res_back;
      out_cnt_q    <= cnt_q;
    end
  end

  deq_ram #(
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign ok_o           = out_ok_q;
  assign popped_value_o = out_popped_q;
  assign front_value_o  = out_front_q;
  assign back_value_o   = out_back_q;
  assign count_o        = out_cnt_q;
  assign is_empty_o     = (out_cnt_q == '0);
  assign is_full_o      = (out_cnt_q == FullCnt);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("element count exceeds depth");

  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("store written and read in the same cycle");

  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == deq_pkg::ST_RESULT) && in_stall_o)
    else $error("accepted beat did not enter the result phase");

  a_refetch_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == deq_pkg::ST_RESULT) && (rd_sel_q != deq_pkg::RD_NONE) |-> !empty)
    else $error("store refetch pending on an empty queue");

endmodule

@@ src/deq_ram.sv @@
`timescale 1ns / 1ps
// Single-port synchronous element store with a registered read.
module deq_ram #(
  parameter int unsigned Depth = 16
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic                            re_i,
  input  logic [$clog2(Depth)-1:0]        addr_i,
  input  deq_pkg::data_t                  wdata_i,
  output deq_pkg::data_t                  rdata_o
);

  deq_pkg::data_t mem_q [Depth];
  deq_pkg::data_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
